[sv/pip_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the point-in-polygon ray-cast block.
// No dependencies; imported by pip_ctrl, pip_datapath and the top level.
package pip_pkg;

   localparam int CoordBits   = 16;
   localparam int RayMargin   = 5;
   localparam int MinVertices = 3;
   localparam int CountOutBits = 7;

   localparam logic [1:0] KindClear  = 2'd0;
   localparam logic [1:0] KindAppend = 2'd1;
   localparam logic [1:0] KindQuery  = 2'd2;

   typedef struct packed {
      logic [1:0]                  kind;
      logic signed [CoordBits-1:0] coord_x;
      logic signed [CoordBits-1:0] coord_y;
   } req_type;

   typedef struct packed {
      logic                    inside_res;
      logic                    error;
      logic [CountOutBits-1:0] vertex_count;
   } rsp_type;

   typedef struct packed {
      logic signed [CoordBits-1:0] x;
      logic signed [CoordBits-1:0] y;
   } vertex_type;

   // controller -> datapath
   typedef struct packed {
      logic clear;
      logic append;
      logic walk_start;
      logic walk_step;
      logic rsp_send;
      logic rsp_err;
      logic rsp_use_parity;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic too_few;
      logic in_box;
      logic last_step;
      logic pipe_busy;
   } status_type;

endpackage

[sv/pip_ctrl.sv]
`timescale 1ns / 1ps
// Sequencing state machine: decodes the request kind and steps the edge walk.
// Depends on pip_pkg.
module pip_ctrl
   import pip_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] kind,
   input  status_type status,
   output logic       busy,
   output cmd_type    cmd
);

   localparam logic [1:0] StIdle  = 2'd0;
   localparam logic [1:0] StWalk  = 2'd1;
   localparam logic [1:0] StDrain = 2'd2;

   logic [1:0] state_ff, state_in;

   assign busy = (state_ff != StIdle);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         StIdle: begin
            if (start) begin
               cmd.rsp_send = 1'b1;
               unique case (kind)
                  KindClear: begin
                     cmd.clear = 1'b1;
                  end
                  KindAppend: begin
                     if (status.full) cmd.rsp_err = 1'b1;
                     else cmd.append = 1'b1;
                  end
                  KindQuery: begin
                     if (status.too_few) begin
                        cmd.rsp_err = 1'b1;
                     end else if (status.in_box) begin
                        cmd.rsp_send   = 1'b0;
                        cmd.walk_start = 1'b1;
                        state_in       = StWalk;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         StWalk: begin
            cmd.walk_step = 1'b1;
            if (status.last_step) state_in = StDrain;
         end
         StDrain: begin
            if (!status.pipe_busy) begin
               cmd.rsp_send       = 1'b1;
               cmd.rsp_use_parity = 1'b1;
               state_in           = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= StIdle;
      else state_ff <= state_in;
   end

   a_walk_needs_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_start |=> state_ff == StWalk)
      else $error("walk start did not enter walk state");

   a_no_send_in_walk: assert property (@(posedge clock) disable iff (reset)
      state_ff == StWalk |-> !cmd.rsp_send)
      else $error("response sent in the middle of a walk");

endmodule

[sv/pip_datapath.sv]
`timescale 1ns / 1ps
// Vertex memory, bounding box, vertex count and the pipelined edge-crossing test.
// Depends on pip_pkg; driven by pip_ctrl commands.
module pip_datapath
   import pip_pkg::*;
#(
   parameter int MAX_VERTICES = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_valid,
   output rsp_type    rsp
);

   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int AW = $clog2(MAX_VERTICES);
   localparam int DW = CoordBits + 1;       // coordinate differences
   localparam int XW = CoordBits + 2;       // ray length
   localparam int PW = 2 * CoordBits + 4;   // products and their sum

   // vertex store and its bookkeeping
   vertex_type vert_mem_ff [MAX_VERTICES];
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] idx_ff, idx_in, rd_addr;
   logic signed [CoordBits-1:0] box_left_ff, box_right_ff, box_top_ff, box_bottom_ff;

   // query point and ray
   logic signed [CoordBits-1:0] px_ff, py_ff;
   logic signed [XW-1:0] dx_ff, dx_in;

   // pipeline: memory read, differences, products, parity
   logic       rv_ff, pv_ff, av_ff, bv_ff, ok_b_ff, ok_in;
   vertex_type rd_ff, prev_ff;
   logic signed [DW-1:0] e_a_ff, n_a_ff, bx_a_ff, axp_a_ff;
   logic signed [DW-1:0] e_in, n_in, bx_in, axp_in;
   logic       neg_by;
   logic signed [2*DW-1:0]  p1_raw, p2_raw;
   logic signed [XW+DW-1:0] p3_raw;
   logic signed [PW-1:0] p1_ff, p2_ff, p3_ff, t_sum;
   logic       parity_ff, parity_in, crossed;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff, rsp_in;

   // ---- count, box, memory write ----
   always_comb begin
      count_in = count_ff;
      if (cmd.clear) count_in = '0;
      else if (cmd.append) count_in = count_ff + CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         box_left_ff   <= '0;
         box_right_ff  <= '0;
         box_top_ff    <= '0;
         box_bottom_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (cmd.clear) begin
            box_left_ff   <= '0;
            box_right_ff  <= '0;
            box_top_ff    <= '0;
            box_bottom_ff <= '0;
         end else if (cmd.append) begin
            if (count_ff == '0) begin
               box_left_ff   <= req.coord_x;
               box_right_ff  <= req.coord_x;
               box_top_ff    <= req.coord_y;
               box_bottom_ff <= req.coord_y;
            end else begin
               if (req.coord_x < box_left_ff)   box_left_ff   <= req.coord_x;
               if (req.coord_x > box_right_ff)  box_right_ff  <= req.coord_x;
               if (req.coord_y < box_top_ff)    box_top_ff    <= req.coord_y;
               if (req.coord_y > box_bottom_ff) box_bottom_ff <= req.coord_y;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append) begin
         vert_mem_ff[AW'(count_ff)] <= '{x: req.coord_x, y: req.coord_y};
      end
   end

   // ---- walk addressing: last vertex first, then 0 .. count-1 ----
   assign rd_addr = cmd.walk_start ? AW'(count_ff - CW'(1)) : idx_ff;

   always_comb begin
      idx_in = idx_ff;
      if (cmd.walk_start) idx_in = '0;
      else if (cmd.walk_step) idx_in = idx_ff + AW'(1);
   end

   assign dx_in = XW'(box_right_ff) + XW'(RayMargin) - XW'(req.coord_x);

   always_ff @(posedge clock) begin
      if (cmd.walk_start || cmd.walk_step) rd_ff <= vert_mem_ff[rd_addr];
      idx_ff <= idx_in;
      if (cmd.walk_start) begin
         px_ff <= req.coord_x;
         py_ff <= req.coord_y;
         dx_ff <= dx_in;
      end
   end

   // ---- stage A: edge differences, oriented so that n >= 0 ----
   assign neg_by = (rd_ff.y < prev_ff.y);
   assign e_in   = neg_by ? DW'(prev_ff.y) - DW'(py_ff) : DW'(py_ff) - DW'(prev_ff.y);
   assign n_in   = neg_by ? DW'(prev_ff.y) - DW'(rd_ff.y) : DW'(rd_ff.y) - DW'(prev_ff.y);
   assign bx_in  = DW'(rd_ff.x) - DW'(prev_ff.x);
   assign axp_in = DW'(prev_ff.x) - DW'(px_ff);

   always_ff @(posedge clock) begin
      if (rv_ff) begin
         prev_ff  <= rd_ff;
         e_a_ff   <= e_in;
         n_a_ff   <= n_in;
         bx_a_ff  <= bx_in;
         axp_a_ff <= axp_in;
      end
   end

   // ---- stage B: edge parameter range check and the three products ----
   // horizontal edge gives n == 0, which the e range check rejects
   assign ok_in  = !e_a_ff[DW-1] && (e_a_ff < n_a_ff);
   assign p1_raw = axp_a_ff * n_a_ff;
   assign p2_raw = e_a_ff * bx_a_ff;
   assign p3_raw = dx_ff * n_a_ff;

   always_ff @(posedge clock) begin
      ok_b_ff <= ok_in;
      p1_ff   <= PW'(p1_raw);
      p2_ff   <= PW'(p2_raw);
      p3_ff   <= PW'(p3_raw);
   end

   // ---- stage C: ray parameter in [0,1) and parity ----
   assign t_sum   = p1_ff + p2_ff;
   assign crossed = bv_ff && ok_b_ff && !t_sum[PW-1] && (t_sum < p3_ff);

   always_comb begin
      parity_in = parity_ff;
      if (cmd.walk_start) parity_in = 1'b0;
      else if (crossed) parity_in = !parity_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff     <= 1'b0;
         pv_ff     <= 1'b0;
         av_ff     <= 1'b0;
         bv_ff     <= 1'b0;
         parity_ff <= 1'b0;
      end else begin
         rv_ff     <= cmd.walk_start || cmd.walk_step;
         // first read of a walk only primes the previous vertex
         if (cmd.walk_start) pv_ff <= 1'b0;
         else if (rv_ff) pv_ff <= 1'b1;
         av_ff     <= rv_ff && pv_ff;
         bv_ff     <= av_ff;
         parity_ff <= parity_in;
      end
   end

   // ---- response register ----
   always_comb begin
      rsp_in.inside_res   = cmd.rsp_use_parity && parity_ff;
      rsp_in.error        = cmd.rsp_err;
      rsp_in.vertex_count = CountOutBits'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= cmd.rsp_send;
      if (cmd.rsp_send) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // ---- status ----
   assign status.full      = (count_ff == CW'(MAX_VERTICES));
   assign status.too_few   = (count_ff < CW'(MinVertices));
   assign status.in_box    = (req.coord_x >= box_left_ff) && (req.coord_x <= box_right_ff) &&
                             (req.coord_y >= box_top_ff) && (req.coord_y <= box_bottom_ff);
   assign status.last_step = (CW'(idx_ff) == count_ff - CW'(1));
   assign status.pipe_busy = rv_ff || av_ff || bv_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_VERTICES))
      else $error("vertex count beyond store depth");

   a_no_write_in_walk: assert property (@(posedge clock) disable iff (reset)
      (cmd.walk_start || cmd.walk_step) |-> !(cmd.append || cmd.clear))
      else $error("store modified during a walk");

   a_parity_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_use_parity |-> !(rv_ff || av_ff || bv_ff))
      else $error("parity taken before the edge pipeline drained");

   a_walk_has_polygon: assert property (@(posedge clock) disable iff (reset)
      bv_ff |-> count_ff >= CW'(MinVertices))
      else $error("edge test with fewer than three vertices");

endmodule

[sv/point_in_polygon_ray_cast.sv]
`timescale 1ns / 1ps
// Clear, append and out-of-range or rejected queries: result in the next cycle after transfer.
// Walked query: one memory read per cycle through a
// four-deep read/difference/multiply/parity pipeline; busy holds off the next item.
// Synchronous active-high reset empties the polygon and drops any query in flight.
// The result strobe is one cycle wide and cannot be stalled by the receiver.
module point_in_polygon_ray_cast
   import pip_pkg::*;
#(
   parameter int MAX_VERTICES = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   cmd_type    cmd;
   status_type status;
   logic       ctrl_busy;
   logic       req_take;

   assign busy     = ctrl_busy;
   assign req_take = start && !ctrl_busy;

   pip_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (req_take),
      .kind   (req_item.kind),
      .status (status),
      .busy   (ctrl_busy),
      .cmd    (cmd)
   );

   pip_datapath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req_item),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_strobe),
      .rsp       (rsp_item)
   );

endmodule
